FILE: src/rgba_median3x3_filter_core_macros.svh
// Assertion macros used by the median filter core RTL.
// No dependencies.
`ifndef RGBA_MEDIAN3X3_FILTER_CORE_MACROS_SVH
`define RGBA_MEDIAN3X3_FILTER_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RMF_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RMF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

FILE: src/rmf_pkg.sv
// Package for the RGBA 3x3 median filter: constants and the sorting network.
// No dependencies.
package rmf_pkg;

  localparam int unsigned RegBits = 12;
  localparam int unsigned MaxHeight = 4095;
  localparam int unsigned NetSteps = 19;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef logic [3:0] net_idx_t;

  // Compare-swap pairs of the median-of-nine network.
  function automatic net_idx_t net_lo(input int unsigned s);
    net_idx_t r;
    case (s)
      0: r = 4'd1;  1: r = 4'd4;  2: r = 4'd7;  3: r = 4'd0;  4: r = 4'd3;
      5: r = 4'd6;  6: r = 4'd1;  7: r = 4'd4;  8: r = 4'd7;  9: r = 4'd0;
      10: r = 4'd5; 11: r = 4'd4; 12: r = 4'd3; 13: r = 4'd1; 14: r = 4'd2;
      15: r = 4'd4; 16: r = 4'd4; 17: r = 4'd6; default: r = 4'd4;
    endcase
    return r;
  endfunction

  function automatic net_idx_t net_hi(input int unsigned s);
    net_idx_t r;
    case (s)
      0: r = 4'd2;  1: r = 4'd5;  2: r = 4'd8;  3: r = 4'd1;  4: r = 4'd4;
      5: r = 4'd7;  6: r = 4'd2;  7: r = 4'd5;  8: r = 4'd8;  9: r = 4'd3;
      10: r = 4'd8; 11: r = 4'd7; 12: r = 4'd6; 13: r = 4'd4; 14: r = 4'd5;
      15: r = 4'd7; 16: r = 4'd2; 17: r = 4'd4; default: r = 4'd2;
    endcase
    return r;
  endfunction

endpackage

FILE: src/rmf_median9.sv
// Median of nine values with the 19-step compare-swap network, registered.
// Depends on rmf_pkg.
module rmf_median9 #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                      clk_i,
  input  logic [9*CHANNEL_BITS-1:0] vals_i,
  input  logic                      en_i,
  output logic [CHANNEL_BITS-1:0]   med_o
);

  logic [CHANNEL_BITS-1:0] v [9];
  logic [CHANNEL_BITS-1:0] t;
  logic [CHANNEL_BITS-1:0] med_d, med_q;

  always_comb begin
    t = '0;
    for (int k = 0; k < 9; k++) begin
      v[k] = vals_i[k*CHANNEL_BITS +: CHANNEL_BITS];
    end
    for (int s = 0; s < rmf_pkg::NetSteps; s++) begin
      if (v[rmf_pkg::net_lo(s)] > v[rmf_pkg::net_hi(s)]) begin
        t = v[rmf_pkg::net_lo(s)];
        v[rmf_pkg::net_lo(s)] = v[rmf_pkg::net_hi(s)];
        v[rmf_pkg::net_hi(s)] = t;
      end
    end
    med_d = v[4];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      med_q <= med_d;
    end
  end

  assign med_o = med_q;

endmodule

FILE: src/rgba_median3x3_filter_core.sv
// Streaming 3x3 RGBA median, edge replication, one pixel per clock if ready.
// Depends on rmf_pkg, rmf_median9 and the assertion macro header.
//
// Usage: pixels enter in raster order on the input channel (valid/ready);
// command_i = drain feeds a step without a pixel (dropped inside a frame).
// After a frame's last pixel, image_width + 1 drain steps flush the last row;
// the final result carries frame_end_o. Each result lags its pixel by
// one row plus one pixel. The block takes one transaction per cycle while
// in_ready_o is high. The line stores are read when a transaction is taken;
// the window and median networks then work on the registered reads in
// stage 1, from which a result is loaded into the output register for the
// receiver to take. A transaction with no result vanishes in that pipe.
// When the receiver stalls, the pipe holds and in_ready_o drops only while
// both the output register and the stage behind it are full.
// Reset clears counters, the window and valid flags and sets the width to
// 640 and the height to 480; the line stores are not cleared, since edge
// replication never selects entries that were not written this frame.
// Configuration must be written by the user through the APB port while the
// block is idle; the block itself does not enforce this.
`include "rgba_median3x3_filter_core_macros.svh"
module rgba_median3x3_filter_core #(
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [CHANNEL_BITS-1:0] pix_red_i,
  input  logic [CHANNEL_BITS-1:0] pix_green_i,
  input  logic [CHANNEL_BITS-1:0] pix_blue_i,
  input  logic [CHANNEL_BITS-1:0] pix_alpha_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CHANNEL_BITS-1:0] med_red_o,
  output logic [CHANNEL_BITS-1:0] med_green_o,
  output logic [CHANNEL_BITS-1:0] med_blue_o,
  output logic [CHANNEL_BITS-1:0] out_alpha_o,
  output logic                    frame_end_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned PW = 4 * CB;
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RB = rmf_pkg::RegBits;

  typedef logic [PW-1:0] pix_t;

  // Emit descriptor: window rows/columns to use for one result.
  typedef struct packed {
    logic       valid;
    logic [1:0] tr;
    logic [1:0] br;
    logic [1:0] lc;
    logic [1:0] cc;
    logic       fe;
  } emit_t;

  // ---------------- configuration ----------------
  logic [RB-1:0] width_q, height_q;
  logic          reg_idx;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RB'(640);
      height_q <= RB'(480);
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) begin
      unique case (reg_idx)
        rmf_pkg::REG_WIDTH:  width_q  <= pwdata[RB-1:0];
        rmf_pkg::REG_HEIGHT: height_q <= pwdata[RB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        rmf_pkg::REG_WIDTH:  prdata[RB-1:0] = width_q;
        rmf_pkg::REG_HEIGHT: prdata[RB-1:0] = height_q;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [RB-1:0] h_eff;
  always_comb begin
    if (width_q < RB'(2)) w_eff = CW'(2);
    else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    h_eff = (height_q < RB'(2)) ? RB'(2) : height_q;
  end

  // ---------------- handshake / pipeline ----------------
  logic s1_valid_q, out_valid_q;
  logic s1_adv, out_load, accept;
  logic s1_has_res;
  assign out_load   = s1_valid_q && s1_has_res && (!out_valid_q || out_ready_i);
  assign s1_adv     = !s1_valid_q || !s1_has_res || out_load;
  assign in_ready_o = s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------- stage 0: counters and line store access ----------------
  logic [CW-1:0] col_q, drain_q;
  logic [RB-1:0] row_q;
  logic          in_frame, is_drain, take;
  logic [CW-1:0] x, dx;
  logic [AW-1:0] addr;
  pix_t          pix;

  assign in_frame = row_q < h_eff;
  assign is_drain = (command_i == rmf_pkg::CMD_DRAIN);
  assign take     = accept && !(in_frame && is_drain);
  assign x        = (col_q >= w_eff) ? w_eff - CW'(1) : col_q;
  assign dx       = (drain_q > w_eff) ? w_eff : drain_q;
  assign pix      = {pix_alpha_i, pix_blue_i, pix_green_i, pix_red_i};
  assign addr     = in_frame ? x[AW-1:0] : ((dx == w_eff) ? '0 : dx[AW-1:0]);

  emit_t e0_d, e1_d;   // first and second result candidates
  logic  shift_d, final_d;

  always_comb begin
    e0_d = '0;
    e1_d = '0;
    shift_d = 1'b0;
    final_d = 1'b0;
    if (in_frame) begin
      shift_d = 1'b1;
      if (x == '0 && row_q >= RB'(2)) begin
        e0_d = '{1'b1, (row_q == RB'(2)) ? 2'd1 : 2'd0, 2'd2, 2'd1, 2'd2, 1'b0};
      end
      if (x >= CW'(1) && row_q >= RB'(1)) begin
        e1_d = '{1'b1, (row_q == RB'(1)) ? 2'd1 : 2'd0, 2'd2,
                 (x == CW'(1)) ? 2'd1 : 2'd0, 2'd1, 1'b0};
      end
    end else if (dx == w_eff) begin
      final_d = 1'b1;
      e0_d = '{1'b1, 2'd0, 2'd1, 2'd1, 2'd2, 1'b1};
    end else if (dx == '0) begin
      shift_d = 1'b1;
      e0_d = '{1'b1, (h_eff == RB'(2)) ? 2'd1 : 2'd0, 2'd2, 2'd1, 2'd2, 1'b0};
    end else begin
      shift_d = 1'b1;
      e1_d = '{1'b1, 2'd0, 2'd1, (dx == CW'(1)) ? 2'd1 : 2'd0, 2'd1, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else if (take) begin
      if (in_frame) begin
        if (x + CW'(1) >= w_eff) begin
          col_q <= '0;
          row_q <= row_q + RB'(1);
        end else begin
          col_q <= x + CW'(1);
        end
      end else if (final_d) begin
        col_q   <= '0;
        row_q   <= '0;
        drain_q <= '0;
      end else begin
        drain_q <= dx + CW'(1);
      end
    end
  end

  // Line stores: one write and one registered read per cycle each.
  pix_t store_a [MAX_WIDTH];
  pix_t store_b [MAX_WIDTH];
  pix_t top_q, mid_q, newp_q;
  logic          a_wr_q;
  logic [AW-1:0] a_wr_addr_q;

  // The older row moves into store_a in the next cycle, from the registered
  // read of store_b.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_wr_q <= 1'b0;
    end else begin
      a_wr_q <= take && in_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_frame) begin
      store_b[addr] <= pix;
      a_wr_addr_q   <= addr;
    end
    if (a_wr_q) begin
      store_a[a_wr_addr_q] <= mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      top_q  <= store_a[addr];
      mid_q  <= store_b[addr];
      newp_q <= in_frame ? pix : '0;
    end
  end

  // Same-address back-to-back is impossible for width >= 2 except after the
  // final drain (address 0 twice); row data is then unchanged, so the read
  // above sees the right values, and the delayed store_a write never meets
  // a read of its own address.

  emit_t e0_q, e1_q;
  logic  shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      e0_q       <= '0;
      e1_q       <= '0;
      shift_q    <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= take;
      e0_q       <= e0_d;
      e1_q       <= e1_d;
      shift_q    <= shift_d;
    end
  end

  // ---------------- stage 1: window and medians ----------------
  pix_t win_q [9];
  pix_t win_n [9];
  emit_t sel;

  assign s1_has_res = e0_q.valid || e1_q.valid;
  assign sel = e0_q.valid ? e0_q : e1_q;

  always_comb begin
    for (int k = 0; k < 9; k++) win_n[k] = win_q[k];
    if (shift_q) begin
      win_n[0] = win_q[1]; win_n[1] = win_q[2]; win_n[2] = top_q;
      win_n[3] = win_q[4]; win_n[4] = win_q[5]; win_n[5] = mid_q;
      win_n[6] = win_q[7]; win_n[7] = win_q[8]; win_n[8] = newp_q;
    end
  end

  // First candidate reads the window before the shift, the second after it.
  pix_t src [9];
  logic [1:0] rows [3];
  logic [1:0] cols [3];
  logic [9*CB-1:0] nv [3];
  pix_t          cpix;

  always_comb begin
    for (int k = 0; k < 9; k++) src[k] = e0_q.valid ? win_q[k] : win_n[k];
    rows[0] = sel.tr; rows[1] = 2'd1; rows[2] = sel.br;
    cols[0] = sel.lc; cols[1] = sel.cc; cols[2] = 2'd2;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          nv[c][(i*3+j)*CB +: CB] =
            src[4'(rows[i]) * 4'd3 + 4'(cols[j])][c*CB +: CB];
        end
      end
    end
    cpix = src[4'd3 + 4'(sel.cc)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (s1_valid_q && s1_adv) begin
      for (int k = 0; k < 9; k++) win_q[k] <= win_n[k];
    end
  end

  rmf_median9 #(.CHANNEL_BITS(CB)) u_med_r (
    .clk_i(clk_i), .vals_i(nv[0]), .en_i(out_load), .med_o(med_red_o));
  rmf_median9 #(.CHANNEL_BITS(CB)) u_med_g (
    .clk_i(clk_i), .vals_i(nv[1]), .en_i(out_load), .med_o(med_green_o));
  rmf_median9 #(.CHANNEL_BITS(CB)) u_med_b (
    .clk_i(clk_i), .vals_i(nv[2]), .en_i(out_load), .med_o(med_blue_o));

  logic [CB-1:0] alpha_q;
  logic          fe_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      alpha_q <= cpix[3*CB +: CB];
      fe_q    <= sel.fe;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_alpha_o = alpha_q;
  assign frame_end_o = fe_q;

  // At most one result candidate per transaction.
  `RMF_ASSERT_IMP(a_one_result, clk_i, rst_ni, s1_valid_q, !(e0_q.valid && e1_q.valid))
  // A full output register that is not taken blocks loading.
  `RMF_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i, !out_load)
  // Loading always presents a result in the next cycle.
  `RMF_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_q)
  // The frame-ending result clears the position counters.
  `RMF_ASSERT_NEXT(a_frame_reset, clk_i, rst_ni, take && final_d,
                   row_q == '0 && col_q == '0 && drain_q == '0)

endmodule
